// ----- sv/segment_box_slab_test_assert.svh -----
// Assertion macros for the segment box slab test.
`ifndef SEGMENT_BOX_SLAB_TEST_ASSERT_SVH
`define SEGMENT_BOX_SLAB_TEST_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define SBS_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define SBS_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

// ----- sv/sbs_pkg.sv -----
// Shared constants for the segment box slab test.
package sbs_pkg;
   localparam int COORD_BITS_DEF = 32;
   localparam int FRACTION_BITS_DEF = 16;
   localparam int AXES = 3;
   localparam int ENTRY_BITS = 17;
   localparam int REG_IDX_BITS = 3;
   localparam logic [REG_IDX_BITS-1:0] REG_MIN_X = 3'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_MIN_Y = 3'd1;
   localparam logic [REG_IDX_BITS-1:0] REG_MIN_Z = 3'd2;
   localparam logic [REG_IDX_BITS-1:0] REG_MAX_X = 3'd3;
   localparam logic [REG_IDX_BITS-1:0] REG_MAX_Y = 3'd4;
   localparam logic [REG_IDX_BITS-1:0] REG_MAX_Z = 3'd5;
endpackage

// ----- sv/sbs_axis_setup.sv -----
// Per-axis slab classification: reject flag, divide flags, numerators and divisor.
module sbs_axis_setup #(
   parameter int COORD_BITS = sbs_pkg::COORD_BITS_DEF
) (
   input  logic signed [COORD_BITS-1:0] s,
   input  logic signed [COORD_BITS-1:0] e,
   input  logic signed [COORD_BITS-1:0] lo,
   input  logic signed [COORD_BITS-1:0] hi,
   output logic                         reject,
   output logic                         in_div,
   output logic                         out_div,
   output logic [COORD_BITS:0]          num_in,
   output logic [COORD_BITS:0]          num_out,
   output logic [COORD_BITS:0]          den
);
   logic signed [COORD_BITS:0] d, dl, dh;
   logic [COORD_BITS:0] ml, mh;
   logic up;

   always_comb begin
      d  = {e[COORD_BITS-1], e} - {s[COORD_BITS-1], s};
      dl = {lo[COORD_BITS-1], lo} - {s[COORD_BITS-1], s};
      dh = {hi[COORD_BITS-1], hi} - {s[COORD_BITS-1], s};
      ml = dl[COORD_BITS] ? -dl : dl;
      mh = dh[COORD_BITS] ? -dh : dh;
      den = d[COORD_BITS] ? -d : d;
      up = s < e;
      if (up) begin
         reject  = (s > hi) || (e < lo);
         in_div  = s < lo;
         out_div = e > hi;
         num_in  = ml;
         num_out = mh;
      end else begin
         reject  = (e > hi) || (s < lo);
         in_div  = s > hi;
         out_div = e < lo;
         num_in  = mh;
         num_out = ml;
      end
   end
endmodule

// ----- sv/sbs_div_stage.sv -----
// One restoring step of the fractional divider, registered, with stall.
module sbs_div_stage #(
   parameter int COORD_BITS = sbs_pkg::COORD_BITS_DEF,
   parameter int FRACTION_BITS = sbs_pkg::FRACTION_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       adv,
   input  logic [COORD_BITS+1:0]      rem_in_v,
   input  logic [COORD_BITS:0]        den_v,
   input  logic [FRACTION_BITS:0]     q_v,
   output logic [COORD_BITS+1:0]      rem_ff,
   output logic [COORD_BITS:0]        den_ff,
   output logic [FRACTION_BITS:0]     q_ff
);
   logic [COORD_BITS+1:0] sh, rem_in;
   logic [FRACTION_BITS:0] q_in;
   logic ge;

   always_comb begin
      sh = {rem_in_v[COORD_BITS:0], 1'b0};
      ge = sh >= {1'b0, den_v};
      rem_in = ge ? sh - {1'b0, den_v} : sh;
      q_in = {q_v[FRACTION_BITS-1:0], ge};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff <= rem_in;
         den_ff <= den_v;
         q_ff   <= q_in;
      end
   end
endmodule

// ----- sv/segment_box_slab_test.sv -----
// Top level: pipelined segment versus box slab test.
// Path of a request: the stage-0 registers, the divider step registers, then the result register.
// Throughput: one word per cycle unless a held result word stalls the output, which freezes every stage at once.
// The six divider lanes do one restoring step per pipeline stage.
// Reset clears valid bits and the box registers to zero.
`include "segment_box_slab_test_assert.svh"
module segment_box_slab_test #(
   parameter int COORD_BITS = sbs_pkg::COORD_BITS_DEF,
   parameter int FRACTION_BITS = sbs_pkg::FRACTION_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_BITS-1:0]  req_start_x,
   input  logic signed [COORD_BITS-1:0]  req_start_y,
   input  logic signed [COORD_BITS-1:0]  req_start_z,
   input  logic signed [COORD_BITS-1:0]  req_end_x,
   input  logic signed [COORD_BITS-1:0]  req_end_y,
   input  logic signed [COORD_BITS-1:0]  req_end_z,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_hit,
   output logic [sbs_pkg::ENTRY_BITS-1:0] rsp_entry_x,
   output logic [sbs_pkg::ENTRY_BITS-1:0] rsp_entry_y,
   output logic [sbs_pkg::ENTRY_BITS-1:0] rsp_entry_z,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [sbs_pkg::REG_IDX_BITS-1:0] csr_index,
   input  logic signed [COORD_BITS-1:0]  csr_data
);
   localparam int AX = sbs_pkg::AXES;
   localparam int LANES = 2 * AX;
   localparam int STEPS = FRACTION_BITS;
   localparam int DEPTH = STEPS + 2;

   logic signed [COORD_BITS-1:0] box_ff [LANES];
   logic adv;
   logic [DEPTH-1:0] vld_ff;
   // Per-word control travelling beside the divider lanes.
   logic [DEPTH-2:0] rej_ff;
   logic [LANES-1:0] dodiv_ff [DEPTH-1];

   logic signed [COORD_BITS-1:0] sv [AX];
   logic signed [COORD_BITS-1:0] ev [AX];
   logic [AX-1:0] rej_c;
   logic [LANES-1:0] dodiv_c;
   logic [COORD_BITS:0] num_c [LANES];
   logic [COORD_BITS:0] den_c [LANES];

   logic [COORD_BITS+1:0] rem_s [LANES][STEPS+1];
   logic [COORD_BITS:0]   den_s [LANES][STEPS+1];
   logic [FRACTION_BITS:0] q_s  [LANES][STEPS+1];

   assign csr_ready = 1'b1;
   assign adv = !rsp_stall || !vld_ff[DEPTH-1];
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LANES; i++) box_ff[i] <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            sbs_pkg::REG_MIN_X: box_ff[0] <= csr_data;
            sbs_pkg::REG_MIN_Y: box_ff[1] <= csr_data;
            sbs_pkg::REG_MIN_Z: box_ff[2] <= csr_data;
            sbs_pkg::REG_MAX_X: box_ff[3] <= csr_data;
            sbs_pkg::REG_MAX_Y: box_ff[4] <= csr_data;
            sbs_pkg::REG_MAX_Z: box_ff[5] <= csr_data;
            default: ;
         endcase
      end
   end

   assign sv[0] = req_start_x; assign sv[1] = req_start_y; assign sv[2] = req_start_z;
   assign ev[0] = req_end_x;   assign ev[1] = req_end_y;   assign ev[2] = req_end_z;

   // Stage 0: classification, numerator and divisor per axis.
   for (genvar a = 0; a < AX; a++) begin : g_axis
      sbs_axis_setup #(.COORD_BITS(COORD_BITS)) u_setup (
         .s(sv[a]), .e(ev[a]), .lo(box_ff[a]), .hi(box_ff[a+AX]),
         .reject(rej_c[a]), .in_div(dodiv_c[a]), .out_div(dodiv_c[a+AX]),
         .num_in(num_c[a]), .num_out(num_c[a+AX]), .den(den_c[a]));
      assign den_c[a+AX] = den_c[a];
   end

   logic [COORD_BITS+1:0] rem0_ff [LANES];
   logic [COORD_BITS:0]   den0_ff [LANES];
   logic [LANES-1:0]      full_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < LANES; l++) begin
            // A quotient of one arises only when numerator meets divisor; the
            // remainder then starts at zero so that the fraction bits stay clear.
            rem0_ff[l] <= (num_c[l] >= den_c[l]) ? '0 : {1'b0, num_c[l]};
            den0_ff[l] <= den_c[l];
            full_ff[l] <= num_c[l] >= den_c[l];
         end
         rej_ff[0] <= |rej_c;
         dodiv_ff[0] <= dodiv_c;
         for (int k = 1; k < DEPTH - 1; k++) begin
            rej_ff[k] <= rej_ff[k-1];
            dodiv_ff[k] <= dodiv_ff[k-1];
         end
      end
   end

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      assign rem_s[l][0] = rem0_ff[l];
      assign den_s[l][0] = den0_ff[l];
      assign q_s[l][0] = {full_ff[l], {FRACTION_BITS{1'b0}}};
      for (genvar k = 0; k < STEPS; k++) begin : g_step
         logic [FRACTION_BITS:0] qk;
         // The full flag sits in the top bit and is carried along unchanged.
         sbs_div_stage #(.COORD_BITS(COORD_BITS), .FRACTION_BITS(FRACTION_BITS)) u_step (
            .clock(clock), .adv(adv), .rem_in_v(rem_s[l][k]), .den_v(den_s[l][k]),
            .q_v({1'b0, q_s[l][k][FRACTION_BITS-1:0]}),
            .rem_ff(rem_s[l][k+1]), .den_ff(den_s[l][k+1]), .q_ff(qk));
         logic full_k_ff;
         always_ff @(posedge clock) begin
            if (adv) full_k_ff <= q_s[l][k][FRACTION_BITS];
         end
         assign q_s[l][k+1] = {full_k_ff, qk[FRACTION_BITS-1:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[DEPTH-2:0], req_valid};
      end
   end

   // Final stage: pick parameters, combine axes in order.
   logic [FRACTION_BITS:0] tin [AX];
   logic [FRACTION_BITS:0] tout [AX];
   logic hit_c;
   logic [FRACTION_BITS:0] bin, bout;
   logic hit_ff;
   logic [sbs_pkg::ENTRY_BITS-1:0] ent_ff [AX];
   localparam logic [FRACTION_BITS:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};

   always_comb begin
      for (int a = 0; a < AX; a++) begin
         tin[a]  = (dodiv_ff[DEPTH-2][a] && den_s[a][STEPS] != '0)
                   ? q_s[a][STEPS] : '0;
         tout[a] = dodiv_ff[DEPTH-2][a+AX]
                   ? (den_s[a+AX][STEPS] != '0 ? q_s[a+AX][STEPS] : '0) : ONE;
      end
      hit_c = !rej_ff[DEPTH-2];
      bin = '0;
      bout = ONE;
      for (int a = 0; a < AX; a++) begin
         if (bin < tin[a]) bin = tin[a];
         if (bout > tout[a]) bout = tout[a];
         if (bout < bin) hit_c = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hit_ff <= hit_c;
         for (int a = 0; a < AX; a++) begin
            ent_ff[a] <= hit_c ? sbs_pkg::ENTRY_BITS'(tin[a]) : '0;
         end
      end
   end

   assign rsp_valid = vld_ff[DEPTH-1];
   assign rsp_hit = hit_ff;
   assign rsp_entry_x = ent_ff[0];
   assign rsp_entry_y = ent_ff[1];
   assign rsp_entry_z = ent_ff[2];

   `SBS_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_hit))
   `SBS_ASSERT_IMP(a_miss_zero, clock, reset, rsp_valid && !rsp_hit, (rsp_entry_x | rsp_entry_y | rsp_entry_z) == '0)
   `SBS_ASSERT_IMP(a_stall, clock, reset, req_stall, rsp_valid && rsp_stall)
endmodule
